// File: hw/rtl/jrc_pkg.sv
`timescale 1ns / 1ps

package jrc_pkg;

  localparam int N_RANGES = 2;
  localparam int MAX_JETS = 16;
  localparam int Q_DEPTH  = 2;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;

  localparam logic [16:0] WEIGHT_ONE  = 17'd65536;
  localparam logic [16:0] WEIGHT_HALF = 17'd32768;

  // register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_PT_MIN  = 3'd0;
  localparam logic [2:0] REG_PT_MAX  = 3'd1;
  localparam logic [2:0] REG_MASK    = 3'd2;
  localparam logic [2:0] REG_FUZZY   = 3'd3;
  localparam logic [2:0] REG_E_INV   = 3'd4;
  localparam logic [2:0] REG_Y_INV   = 3'd5;
  localparam logic [2:0] REG_RANGES  = 3'd6;
  localparam logic [2:0] REG_COUNT   = 3'd7;

  typedef struct packed {
    logic               action;
    logic [3:0]         jet_number;
    logic [19:0]        jet_pt;
    logic signed [15:0] jet_rapidity;
    logic signed [15:0] rapidity_shift;
  } jrc_in_t;

  typedef struct packed {
    logic        matched;
    logic [16:0] cut_weight;
    logic [3:0]  held_jet;
  } jrc_out_t;

  // classified job handed from front to engine
  typedef struct packed {
    logic               clear;
    logic               listed;
    logic [3:0]         jet_number;
    logic [19:0]        jet_pt;
    logic signed [15:0] rapidity;
  } jrc_job_t;

  typedef struct packed {
    logic [19:0] pt_minimum;
    logic [19:0] pt_maximum;
    logic        fuzzy_enable;
    logic [23:0] energy_width_inverse;
    logic [23:0] rapidity_width_inverse;
    logic [63:0] rapidity_ranges;
    logic [1:0]  range_count;
  } jrc_cfg_t;

endpackage

// File: hw/rtl/jrc_front.sv
`timescale 1ns / 1ps

module jrc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jrc_pkg::jrc_in_t  in_data,
  input  logic [15:0]       accept_mask,
  output logic              job_valid,
  input  logic              job_ready,
  output jrc_pkg::jrc_job_t job_data
);

  logic               valid_r, valid_nxt;
  jrc_pkg::jrc_job_t  job_r, job_nxt;
  logic signed [16:0] y_sum;
  logic signed [15:0] y_sat;
  logic               listed;
  logic               accept;

  always_comb begin
    y_sum = 17'(in_data.jet_rapidity) + 17'(in_data.rapidity_shift);
    if (y_sum[16] != y_sum[15]) begin
      y_sat = y_sum[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      y_sat = y_sum[15:0];
    end
    // jet numbers past the jet limit are never in a non-empty mask
    listed = (accept_mask == 16'd0) ||
             ((32'(in_data.jet_number) < 32'(jrc_pkg::MAX_JETS)) &&
              accept_mask[in_data.jet_number]);

    in_ready = !valid_r || job_ready;
    accept   = in_valid && in_ready;

    valid_nxt = valid_r && !job_ready;
    job_nxt   = job_r;
    if (accept) begin
      valid_nxt          = 1'b1;
      job_nxt.clear      = in_data.action;
      job_nxt.listed     = listed;
      job_nxt.jet_number = in_data.jet_number;
      job_nxt.jet_pt     = in_data.jet_pt;
      job_nxt.rapidity   = y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    job_r <= job_nxt;
  end

  assign job_valid = valid_r;
  assign job_data  = job_r;

endmodule

// File: hw/rtl/jrc_queue.sv
`timescale 1ns / 1ps

module jrc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  jrc_pkg::jrc_job_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output jrc_pkg::jrc_job_t pop_data
);

  localparam int PTR_W = (jrc_pkg::Q_DEPTH > 1) ? $clog2(jrc_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(jrc_pkg::Q_DEPTH + 1);

  jrc_pkg::jrc_job_t  mem_r [jrc_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(jrc_pkg::Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    push_ready = (count_r != CNT_W'(jrc_pkg::Q_DEPTH));
    pop_valid  = (count_r != '0);
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];

endmodule

// File: hw/rtl/jrc_back.sv
`timescale 1ns / 1ps

module jrc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jrc_pkg::jrc_cfg_t cfg,
  input  logic              job_valid,
  output logic              job_ready,
  input  jrc_pkg::jrc_job_t job_data,
  output logic              out_valid,
  input  logic              out_ready,
  output jrc_pkg::jrc_out_t out_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_BOUND  = 6'b000010,
    S_WEIGHT = 6'b000100,
    S_ROUND  = 6'b001000,
    S_COMB   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  jrc_pkg::jrc_job_t  job_r, job_nxt;
  logic [1:0]         step_r, step_nxt;     // pt low, pt high, range low, range high
  logic               range_r, range_nxt;
  logic [16:0]        w_r, w_nxt, rw_r, rw_nxt;
  logic signed [45:0] prod_r, prod_nxt;
  logic               dpos_r, dpos_nxt;
  logic               pend_r, pend_nxt;
  logic               tgt_rw_r, tgt_rw_nxt;
  logic               fin_r, fin_nxt;
  logic               hit_r, hit_nxt;
  logic               full_r, full_nxt;
  logic [3:0]         last_r, last_nxt;
  logic [16:0]        weight_r, weight_nxt;
  logic               out_valid_r, out_valid_nxt;
  jrc_pkg::jrc_out_t  out_r, out_nxt;

  logic [1:0]         count_eff;
  logic [31:0]        rword;
  logic signed [15:0] ra, rb, lo, hi;
  logic signed [20:0] diff;
  logic signed [24:0] inv;
  logic signed [20:0] mul_a;
  logic signed [24:0] mul_b;
  logic               bound_pass;
  logic [16:0]        bound_w;
  logic [33:0]        rnd_sum;
  logic [16:0]        rnd;
  logic               out_free;

  always_comb begin
    count_eff = (cfg.range_count > 2'(jrc_pkg::N_RANGES)) ?
                2'(jrc_pkg::N_RANGES) : cfg.range_count;
    rword = cfg.rapidity_ranges[32*range_r +: 32];
    ra    = rword[15:0];
    rb    = rword[31:16];
    lo    = (ra > rb) ? rb : ra;
    hi    = (ra > rb) ? ra : rb;

    case (step_r)
      2'd0:    diff = $signed({1'b0, job_r.jet_pt}) - $signed({1'b0, cfg.pt_minimum});
      2'd1:    diff = $signed({1'b0, cfg.pt_maximum}) - $signed({1'b0, job_r.jet_pt});
      2'd2:    diff = 21'(job_r.rapidity) - 21'(lo);
      default: diff = 21'(hi) - 21'(job_r.rapidity);
    endcase
    inv = step_r[1] ? $signed({1'b0, cfg.rapidity_width_inverse})
                    : $signed({1'b0, cfg.energy_width_inverse});

    // bound weight: clamp(diff*inv + 0.5, 0, 1), taken from the product register
    if (cfg.fuzzy_enable) begin
      bound_pass = (prod_r >= -46'sd32767);
      bound_w    = (prod_r > 46'sd32768) ? jrc_pkg::WEIGHT_ONE
                                         : prod_r[16:0] + jrc_pkg::WEIGHT_HALF;
    end else begin
      bound_pass = dpos_r;
      bound_w    = jrc_pkg::WEIGHT_ONE;
    end

    // Q16 round to nearest, ties up
    rnd_sum = prod_r[33:0] + 34'(jrc_pkg::WEIGHT_HALF);
    rnd     = rnd_sum[32:16];

    out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    step_nxt      = step_r;
    range_nxt     = range_r;
    w_nxt         = w_r;
    rw_nxt        = rw_r;
    dpos_nxt      = dpos_r;
    pend_nxt      = pend_r;
    tgt_rw_nxt    = tgt_rw_r;
    fin_nxt       = fin_r;
    hit_nxt       = hit_r;
    full_nxt      = full_r;
    last_nxt      = last_r;
    weight_nxt    = weight_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    job_ready     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    // retire the pending weight product
    if (((state_r == S_BOUND) || (state_r == S_ROUND)) && pend_r) begin
      if (tgt_rw_r) begin
        rw_nxt = rnd;
      end else begin
        w_nxt = rnd;
      end
    end

    case (state_r)
      S_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          job_nxt = job_data;
          hit_nxt = 1'b0;
          if (job_data.clear) begin
            full_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else if (full_r || !job_data.listed) begin
            state_nxt = S_DONE;
          end else begin
            w_nxt     = jrc_pkg::WEIGHT_ONE;
            rw_nxt    = jrc_pkg::WEIGHT_ONE;
            step_nxt  = 2'd0;
            range_nxt = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = S_BOUND;
          end
        end
      end
      S_BOUND: begin
        mul_a     = diff;
        mul_b     = inv;
        dpos_nxt  = (diff > 21'sd0);
        pend_nxt  = 1'b0;
        state_nxt = S_WEIGHT;
      end
      S_WEIGHT: begin
        if (bound_pass) begin
          mul_a      = $signed({4'd0, (step_r[1] ? rw_r : w_r)});
          mul_b      = $signed({8'd0, bound_w});
          pend_nxt   = 1'b1;
          tgt_rw_nxt = step_r[1];
          if ((step_r == 2'd1) && (count_eff == 2'd0)) begin
            fin_nxt   = 1'b1;
            state_nxt = S_ROUND;
          end else if (step_r == 2'd3) begin
            fin_nxt   = 1'b0;
            state_nxt = S_ROUND;
          end else begin
            step_nxt  = step_r + 2'd1;
            state_nxt = S_BOUND;
          end
        end else if (step_r[1] && ((2'(range_r) + 2'd1) < count_eff)) begin
          // try the next range from a fresh weight
          range_nxt = range_r + 1'b1;
          step_nxt  = 2'd2;
          rw_nxt    = jrc_pkg::WEIGHT_ONE;
          pend_nxt  = 1'b0;
          state_nxt = S_BOUND;
        end else begin
          full_nxt   = 1'b0;
          weight_nxt = '0;
          hit_nxt    = 1'b0;
          state_nxt  = S_DONE;
        end
      end
      S_ROUND: begin
        pend_nxt = 1'b0;
        if (fin_r) begin
          full_nxt   = 1'b1;
          last_nxt   = job_r.jet_number;
          weight_nxt = rnd;
          hit_nxt    = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_COMB;
        end
      end
      S_COMB: begin
        mul_a      = $signed({4'd0, w_r});
        mul_b      = $signed({8'd0, rw_r});
        pend_nxt   = 1'b1;
        tgt_rw_nxt = 1'b0;
        fin_nxt    = 1'b1;
        state_nxt  = S_ROUND;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.matched    = hit_r;
          out_nxt.cut_weight = weight_r;
          out_nxt.held_jet   = last_r;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      fin_r       <= 1'b0;
      full_r      <= 1'b0;
      last_r      <= 4'd0;
      weight_r    <= jrc_pkg::WEIGHT_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      fin_r       <= fin_nxt;
      full_r      <= full_nxt;
      last_r      <= last_nxt;
      weight_r    <= weight_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r    <= job_nxt;
    step_r   <= step_nxt;
    range_r  <= range_nxt;
    w_r      <= w_nxt;
    rw_r     <= rw_nxt;
    prod_r   <= prod_nxt;
    dpos_r   <= dpos_nxt;
    tgt_rw_r <= tgt_rw_nxt;
    hit_r    <= hit_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/fuzzy_jet_region_cut_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   jrc_in_t: action, jet, pt, rapidity, shift
// out_      output     out_valid / out_ready jrc_out_t: matched, cut_weight, held_jet
// config    APB write  psel/penable/pwrite   8 registers at 8*index, 64-bit data
//
// A transaction passes a one-entry front register and a two-entry queue, then the
// engine, which takes a new job only once the last result has gone to the output
// register. A clear or a rejected jet skips the bound steps; the single shared
// 21x25 multiplier is used twice per bound.
// Reset (rst_n low, synchronous) restores register defaults, empties the queue and
// clears the match. Either side may stall: a full output register holds the engine,
// and a full queue drops in_ready.

module fuzzy_jet_region_cut_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jrc_pkg::jrc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jrc_pkg::jrc_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jrc_pkg::ADDR_W-1:0]    paddr,
  input  logic [jrc_pkg::DATA_W-1:0]    pwdata,
  output logic [jrc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // configuration registers
  logic [19:0] pt_min_r, pt_min_nxt;
  logic [19:0] pt_max_r, pt_max_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic        fuzzy_r, fuzzy_nxt;
  logic [23:0] e_inv_r, e_inv_nxt;
  logic [23:0] y_inv_r, y_inv_nxt;
  logic [63:0] ranges_r, ranges_nxt;
  logic [1:0]  count_r, count_nxt;

  logic        wr_en;
  logic [2:0]  reg_idx;

  jrc_pkg::jrc_cfg_t cfg;

  // front -> queue -> engine
  logic              fe_valid, fe_ready;
  jrc_pkg::jrc_job_t fe_job;
  logic              q_valid, be_ready;
  jrc_pkg::jrc_job_t q_job;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_comb begin
    pt_min_nxt = pt_min_r;
    pt_max_nxt = pt_max_r;
    mask_nxt   = mask_r;
    fuzzy_nxt  = fuzzy_r;
    e_inv_nxt  = e_inv_r;
    y_inv_nxt  = y_inv_r;
    ranges_nxt = ranges_r;
    count_nxt  = count_r;
    if (wr_en) begin
      case (reg_idx)
        jrc_pkg::REG_PT_MIN: pt_min_nxt = pwdata[19:0];
        jrc_pkg::REG_PT_MAX: pt_max_nxt = pwdata[19:0];
        jrc_pkg::REG_MASK:   mask_nxt   = pwdata[15:0];
        jrc_pkg::REG_FUZZY:  fuzzy_nxt  = pwdata[0];
        jrc_pkg::REG_E_INV:  e_inv_nxt  = pwdata[23:0];
        jrc_pkg::REG_Y_INV:  y_inv_nxt  = pwdata[23:0];
        jrc_pkg::REG_RANGES: ranges_nxt = pwdata;
        jrc_pkg::REG_COUNT:  count_nxt  = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_min_r <= 20'd0;
      pt_max_r <= 20'hFFFFF;
      mask_r   <= 16'd0;
      fuzzy_r  <= 1'b0;
      e_inv_r  <= 24'd1024;
      y_inv_r  <= 24'd320;
      ranges_r <= 64'd0;
      count_r  <= 2'd0;
    end else begin
      pt_min_r <= pt_min_nxt;
      pt_max_r <= pt_max_nxt;
      mask_r   <= mask_nxt;
      fuzzy_r  <= fuzzy_nxt;
      e_inv_r  <= e_inv_nxt;
      y_inv_r  <= y_inv_nxt;
      ranges_r <= ranges_nxt;
      count_r  <= count_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      jrc_pkg::REG_PT_MIN: prdata = 64'(pt_min_r);
      jrc_pkg::REG_PT_MAX: prdata = 64'(pt_max_r);
      jrc_pkg::REG_MASK:   prdata = 64'(mask_r);
      jrc_pkg::REG_FUZZY:  prdata = 64'(fuzzy_r);
      jrc_pkg::REG_E_INV:  prdata = 64'(e_inv_r);
      jrc_pkg::REG_Y_INV:  prdata = 64'(y_inv_r);
      jrc_pkg::REG_RANGES: prdata = ranges_r;
      jrc_pkg::REG_COUNT:  prdata = 64'(count_r);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pt_minimum             = pt_min_r;
    cfg.pt_maximum             = pt_max_r;
    cfg.fuzzy_enable           = fuzzy_r;
    cfg.energy_width_inverse   = e_inv_r;
    cfg.rapidity_width_inverse = y_inv_r;
    cfg.rapidity_ranges        = ranges_r;
    cfg.range_count            = count_r;
  end

  // front: saturate rapidity, check the accept mask
  jrc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .accept_mask (mask_r),
    .job_valid   (fe_valid),
    .job_ready   (fe_ready),
    .job_data    (fe_job)
  );

  jrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  (fe_job),
    .pop_valid  (q_valid),
    .pop_ready  (be_ready),
    .pop_data   (q_job)
  );

  // engine: region state, bound weights on the shared multiplier, result register
  jrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (q_valid),
    .job_ready (be_ready),
    .job_data  (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_weight_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cut_weight <= jrc_pkg::WEIGHT_ONE))
    else $error("cut weight above one");

  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> fe_valid)
    else $error("accepted transaction not held in front register");

  a_queue_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !be_ready) |=> q_valid)
    else $error("queue lost an entry the engine did not take");
`endif

endmodule

// File: test/region_cut_checker.sv
`timescale 1ns / 1ps

// Watches the jet channel, the result channel and the register port.
// Keeps its own copy of the region state and the settings, predicts every
// result and compares it with what the unit returns.
module region_cut_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  jrc_pkg::jrc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  jrc_pkg::jrc_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output int                fail_count,
  output int                cuts_pending,
  output int                cuts_checked,
  output int                jets_matched
);

  // settings copy
  logic [19:0] lo_pt, hi_pt;
  logic [15:0] jet_mask;
  logic        smear_on;
  logic [23:0] pt_slope, y_slope;
  logic [63:0] y_windows;
  logic [1:0]  window_count;

  // region state
  logic        region_taken;
  logic [3:0]  held_num;
  logic [16:0] held_weight;

  jrc_pkg::jrc_out_t cut_due[$];
  jrc_pkg::jrc_out_t want;
  int fails   = 0;
  int due     = 0;
  int checked = 0;
  int hits    = 0;

  assign fail_count   = fails;
  assign cuts_pending = due;
  assign cuts_checked = checked;
  assign jets_matched = hits;

  task automatic log_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    fails++;
  endtask

  // Q1.16 product, rounded to nearest, ties up
  function automatic logic [16:0] wmul(input logic [16:0] a, input logic [16:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'd32768;
    return p[32:16];
  endfunction

  // One bound a < b with diff = b - a. Returns {pass, running weight}.
  function automatic logic [17:0] bound_step(input longint diff, input logic [23:0] inv,
                                             input logic [16:0] w);
    longint r;
    if (!smear_on) return (diff > 0) ? {1'b1, jrc_pkg::WEIGHT_ONE} : {1'b0, 17'd0};
    r = diff * longint'({40'd0, inv}) + 64'sd32768;
    if (r <= 0) return {1'b0, w};
    if (r > 64'sd65536) r = 64'sd65536;
    return {1'b1, wmul(w, 17'(r))};
  endfunction

  function automatic logic test_jet(input logic [3:0] num, input logic [19:0] pt, input int y);
    logic [17:0] s;
    logic [16:0] w;
    logic [31:0] word;
    int lo, hi, t, n;
    logic in_range;
    w = jrc_pkg::WEIGHT_ONE;
    n = (window_count > jrc_pkg::N_RANGES) ? jrc_pkg::N_RANGES : int'(window_count);
    in_range = (n == 0);
    s = bound_step(longint'(pt) - longint'(lo_pt), pt_slope, w);
    if (s[17]) s = bound_step(longint'(hi_pt) - longint'(pt), pt_slope, s[16:0]);
    if (!s[17]) begin
      held_weight  = 17'd0;
      region_taken = 1'b0;
      return 1'b0;
    end
    w = s[16:0];
    // first window that passes decides the weight
    for (int i = 0; i < n && !in_range; i++) begin
      word = y_windows[32*i +: 32];
      lo = $signed(word[15:0]);
      hi = $signed(word[31:16]);
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      s = bound_step(longint'(y) - longint'(lo), y_slope, jrc_pkg::WEIGHT_ONE);
      if (s[17]) s = bound_step(longint'(hi) - longint'(y), y_slope, s[16:0]);
      if (s[17]) begin
        w = wmul(w, s[16:0]);
        in_range = 1'b1;
      end
    end
    if (!in_range) begin
      held_weight  = 17'd0;
      region_taken = 1'b0;
      return 1'b0;
    end
    region_taken = 1'b1;
    held_num     = num;
    held_weight  = w;
    return 1'b1;
  endfunction

  function automatic jrc_pkg::jrc_out_t cut_jet(input jrc_pkg::jrc_in_t t);
    jrc_pkg::jrc_out_t res;
    int y;
    logic hit;
    y = int'($signed(t.jet_rapidity)) + int'($signed(t.rapidity_shift));
    if (y > 32767) y = 32767;
    else if (y < -32768) y = -32768;
    hit = 1'b0;
    if (t.action) region_taken = 1'b0;
    else if (!region_taken && (jet_mask == 16'd0 || jet_mask[t.jet_number]))
      hit = test_jet(t.jet_number, t.jet_pt, y);
    res.matched    = hit;
    res.cut_weight = held_weight;
    res.held_jet   = held_num;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lo_pt        = 20'd0;
      hi_pt        = 20'hFFFFF;
      jet_mask     = 16'd0;
      smear_on     = 1'b0;
      pt_slope     = 24'd1024;
      y_slope      = 24'd320;
      y_windows    = 64'd0;
      window_count = 2'd0;
      region_taken = 1'b0;
      held_num     = 4'd0;
      held_weight  = jrc_pkg::WEIGHT_ONE;
      cut_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          jrc_pkg::REG_PT_MIN: lo_pt        = pwdata[19:0];
          jrc_pkg::REG_PT_MAX: hi_pt        = pwdata[19:0];
          jrc_pkg::REG_MASK:   jet_mask     = pwdata[15:0];
          jrc_pkg::REG_FUZZY:  smear_on     = pwdata[0];
          jrc_pkg::REG_E_INV:  pt_slope     = pwdata[23:0];
          jrc_pkg::REG_Y_INV:  y_slope      = pwdata[23:0];
          jrc_pkg::REG_RANGES: y_windows    = pwdata;
          jrc_pkg::REG_COUNT:  window_count = pwdata[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (cut_due.size() == 0) begin
          log_mismatch($sformatf("result %h with nothing expected", out_data));
        end else begin
          want = cut_due.pop_front();
          if (out_data.matched !== want.matched)
            log_mismatch($sformatf("matched got %b want %b", out_data.matched, want.matched));
          if (out_data.cut_weight !== want.cut_weight)
            log_mismatch($sformatf("cut_weight got %0d want %0d",
                                   out_data.cut_weight, want.cut_weight));
          if (out_data.held_jet !== want.held_jet)
            log_mismatch($sformatf("held_jet got %0d want %0d",
                                   out_data.held_jet, want.held_jet));
          checked++;
          if (want.matched) hits++;
        end
      end
      if (in_valid && in_ready) cut_due.insert(cut_due.size(), cut_jet(in_data));
    end
    due <= cut_due.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

// Top of the region cut bench: makes the stimulus, drives the register port
// and both handshakes, and gives the verdict. All prediction and comparison
// sits in region_cut_checker.
module tb;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int SETTINGS_PER_PASS = 4;
  localparam int ITEMS_PER_SETTING = 134;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  jrc_pkg::jrc_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  jrc_pkg::jrc_out_t out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [5:0]        paddr     = '0;
  logic [63:0]       pwdata    = '0;
  logic [63:0]       prdata;
  logic              pready;

  int fail_count, cuts_pending, cuts_checked, jets_matched;

  // handshake pressure, percent of cycles spent idle
  int in_gap_pct    = 0;
  int out_stall_pct = 0;

  int cycles        = 0;
  int sent          = 0;
  int settings_used = 0;

  // mirror of what the register file holds, used to aim the stimulus
  logic [19:0] cfg_pt_lo  = 20'd0;
  logic [19:0] cfg_pt_hi  = 20'hFFFFF;
  logic [15:0] cfg_mask   = 16'd0;
  logic        cfg_fuzzy  = 1'b0;
  logic [23:0] cfg_e_inv  = 24'd1024;
  logic [23:0] cfg_y_inv  = 24'd320;
  logic [63:0] cfg_ranges = 64'd0;
  logic [1:0]  cfg_count  = 2'd0;

  fuzzy_jet_region_cut_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  region_cut_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .cuts_pending(cuts_pending),
    .cuts_checked(cuts_checked),
    .jets_matched(jets_matched)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL fuzzy_jet_region_cut_unit");
      $finish;
    end
  end

  // Result side: ready is redrawn every cycle from the current stall rate.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_stall_pct);

  function automatic jrc_pkg::jrc_in_t jet(input logic act, input int num, input int pt,
                                           input int rap, input int shift);
    jrc_pkg::jrc_in_t t;
    t.action         = act;
    t.jet_number     = 4'(num);
    t.jet_pt         = 20'(pt);
    t.jet_rapidity   = 16'(rap);
    t.rapidity_shift = 16'(shift);
    return t;
  endfunction

  // One transaction on the jet channel. Valid only drops when we really idle,
  // so back-to-back items never see a low/high pair in the same step.
  task automatic push_jet(input jrc_pkg::jrc_in_t item);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait until every result has come back. Every item makes
  // exactly one result, so an empty expectation list means the unit is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cuts_pending != 0) @(posedge clk);
  endtask

  // Setup phase, access phase, then the port idles so writes never overlap.
  task automatic program_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the whole mirror into the unit; caller has already settled.
  task automatic apply_setting();
    program_reg(jrc_pkg::REG_PT_MIN, 64'(cfg_pt_lo));
    program_reg(jrc_pkg::REG_PT_MAX, 64'(cfg_pt_hi));
    program_reg(jrc_pkg::REG_MASK,   64'(cfg_mask));
    program_reg(jrc_pkg::REG_FUZZY,  64'(cfg_fuzzy));
    program_reg(jrc_pkg::REG_E_INV,  64'(cfg_e_inv));
    program_reg(jrc_pkg::REG_Y_INV,  64'(cfg_y_inv));
    program_reg(jrc_pkg::REG_RANGES, cfg_ranges);
    program_reg(jrc_pkg::REG_COUNT,  64'(cfg_count));
    settings_used++;
  endtask

  // Smear slopes: off, full scale, narrow, medium, anything.
  function automatic logic [23:0] pick_inv();
    case ($urandom_range(4))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom_range(1, 64));
      3:       return 24'($urandom_range(64, 8192));
      default: return 24'($urandom);
    endcase
  endfunction

  // One rapidity window: mostly small and ordered, some reversed, some wild.
  function automatic logic [31:0] random_window();
    int a, b;
    if ($urandom_range(5) == 0) return $urandom;
    a = int'($urandom_range(8000)) - 4000;
    b = a + int'($urandom_range(6000)) - 1000;
    return {16'(b), 16'(a)};
  endfunction

  // style 0: every register at zero, style 1: every register at its top,
  // anything else: random with a bias toward settings that let jets through.
  task automatic pick_setting(input int style);
    logic [19:0] a, b;
    if (style == 0) begin
      cfg_pt_lo = '0; cfg_pt_hi = '0; cfg_mask = '0; cfg_fuzzy = 1'b0;
      cfg_e_inv = '0; cfg_y_inv = '0; cfg_ranges = '0; cfg_count = '0;
    end else if (style == 1) begin
      cfg_pt_lo = '1; cfg_pt_hi = '1; cfg_mask = '1; cfg_fuzzy = 1'b1;
      cfg_e_inv = '1; cfg_y_inv = '1; cfg_ranges = '1; cfg_count = '1;
    end else begin
      a = 20'($urandom);
      b = 20'($urandom);
      case ($urandom_range(7))
        0:       begin cfg_pt_lo = '0; cfg_pt_hi = '1; end
        1:       begin cfg_pt_lo = (a > b) ? a : b; cfg_pt_hi = (a > b) ? b : a; end
        default: begin cfg_pt_lo = (a > b) ? b : a; cfg_pt_hi = (a > b) ? a : b; end
      endcase
      case ($urandom_range(3))
        0, 1:    cfg_mask = 16'd0;
        2:       cfg_mask = 16'hFFFF;
        default: cfg_mask = 16'($urandom);
      endcase
      cfg_fuzzy  = 1'($urandom_range(1));
      cfg_e_inv  = pick_inv();
      cfg_y_inv  = pick_inv();
      cfg_ranges = {random_window(), random_window()};
      cfg_count  = 2'($urandom_range(3));
    end
  endtask

  // A jet aimed at the current bounds, with offsets on three scales so both
  // sharp edges and smeared slopes get hit.
  function automatic jrc_pkg::jrc_in_t random_jet();
    logic [19:0] pt;
    logic [31:0] word;
    int sc, y, rap, sh;
    case ($urandom_range(2))
      0:       sc = 4;
      1:       sc = 256;
      default: sc = 16384;
    endcase
    case ($urandom_range(3))
      0:       pt = cfg_pt_lo + 20'($urandom_range(2 * sc)) - 20'(sc);
      1:       pt = cfg_pt_hi + 20'($urandom_range(2 * sc)) - 20'(sc);
      2:       pt = 20'($urandom);
      default: pt = cfg_pt_lo + 20'($urandom_range(int'(cfg_pt_hi - cfg_pt_lo)));
    endcase
    word = cfg_ranges[32 * $urandom_range(1) +: 32];
    case ($urandom_range(3))
      0:       y = $signed(word[15:0]);
      1:       y = $signed(word[31:16]);
      2:       y = 0;
      default: y = $signed(16'($urandom));
    endcase
    y = y + int'($urandom_range(2 * sc)) - sc;
    // split y into rapidity and shift; beyond 16 bits the sum saturates
    if (y > 32767) begin
      rap = 32767;
      sh  = y - 32767;
    end else if (y < -32768) begin
      rap = -32768;
      sh  = y + 32768;
    end else begin
      sh  = int'($urandom_range(1024)) - 512;
      rap = y - sh;
      if (rap > 32767 || rap < -32768) begin
        sh  = 0;
        rap = y;
      end
    end
    if ($urandom_range(9) == 0) begin
      rap = int'($urandom);
      sh  = int'($urandom);
    end
    return jet(1'b0, int'($urandom_range(15)), int'(pt), rap, sh);
  endfunction

  // Mostly well formed events: a clear, then one to four jets. The rest is
  // noise with every field random, clears included.
  task automatic run_events(input int n);
    int goal, k;
    goal = sent + n;
    while (sent < goal) begin
      if ($urandom_range(99) < 85) begin
        push_jet(jet(1'b1, int'($urandom_range(15)), int'($urandom),
                     int'($urandom), int'($urandom)));
        k = $urandom_range(1, 4);
        repeat (k) push_jet(random_jet());
      end else begin
        push_jet(jet(1'($urandom_range(1)), int'($urandom_range(15)), int'($urandom),
                     int'($urandom), int'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: sharp bounds, no windows, all jets listed.
    push_jet(jet(1'b1, 15, 20'hFFFFF, 32767, -32768));   // clear with full fields
    push_jet(jet(1'b0, 3, 0, 0, 0));                     // pt equal to minimum fails
    push_jet(jet(1'b0, 4, 20'hFFFFF, 0, 0));             // pt equal to maximum fails
    push_jet(jet(1'b0, 7, 1, -32768, 0));                // passes, region now taken
    push_jet(jet(1'b0, 9, 500, 0, 0));                   // region full, ignored
    push_jet(jet(1'b1, 0, 0, 0, 0));
    push_jet(jet(1'b0, 15, 20'hFFFFE, 32767, 32767));    // any rapidity when no windows
    settle();

    // Directed, smeared: mask holds jets 0 and 15, window 0 reversed,
    // window 1 up to the top, count above the number of windows.
    cfg_pt_lo  = 20'd100;
    cfg_pt_hi  = 20'd50000;
    cfg_mask   = 16'h8001;
    cfg_fuzzy  = 1'b1;
    cfg_e_inv  = 24'd1024;
    cfg_y_inv  = 24'd320;
    cfg_ranges = {16'(32767), 16'(30000), 16'(-2000), 16'(2000)};
    cfg_count  = 2'd3;
    apply_setting();
    push_jet(jet(1'b1, 0, 0, 0, 0));
    push_jet(jet(1'b0, 5, 200, 0, 0));                   // not in mask
    push_jet(jet(1'b0, 0, 100, 0, 0));                   // on the pt edge, half weight
    push_jet(jet(1'b1, 0, 0, 0, 0));
    push_jet(jet(1'b0, 15, 0, 0, 0));                    // far below, weight zero
    push_jet(jet(1'b0, 15, 50000, 32767, 32767));        // saturates high, window 1 edge
    push_jet(jet(1'b1, 0, 0, 0, 0));
    push_jet(jet(1'b0, 0, 300, -32768, -32768));         // saturates low, no window
    push_jet(jet(1'b0, 0, 300, 1000, -500));             // inside the reversed window
    push_jet(jet(1'b1, 0, 0, 0, 0));
    push_jet(jet(1'b0, 15, 40000, 30000, 500));          // misses window 0, takes window 1

    // Random part: three pressure profiles, several settings each.
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0:       begin in_gap_pct = 26; out_stall_pct = 60; end
        1:       begin in_gap_pct = 60; out_stall_pct = 26; end
        default: begin in_gap_pct = 0;  out_stall_pct = 0;  end
      endcase
      for (int s = 0; s < SETTINGS_PER_PASS; s++) begin
        settle();
        pick_setting(pass * SETTINGS_PER_PASS + s);
        apply_setting();
        run_events(ITEMS_PER_SETTING);
      end
    end

    settle();
    repeat (40) @(posedge clk);   // catch any stray result

    $display("run: %0d transactions over %0d register settings, three stall profiles",
             sent, settings_used);
    $display("run: %0d results compared, %0d jets matched, %0d mismatches",
             cuts_checked, jets_matched, fail_count);
    if (fail_count == 0 && cuts_pending == 0)
      $display("PASS fuzzy_jet_region_cut_unit");
    else
      $display("FAIL fuzzy_jet_region_cut_unit");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/jrc_pkg.sv
hw/rtl/jrc_front.sv
hw/rtl/jrc_queue.sv
hw/rtl/jrc_back.sv
hw/rtl/fuzzy_jet_region_cut_unit.sv
test/region_cut_checker.sv
test/tb.sv
